>>> hdl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants for the PCM fade-in / fade-out smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

  // Width of frame counts (packet length, fade length, position)
  localparam int unsigned FRAME_COUNT_BITS = 16;
  // Width of one PCM sample
  localparam int unsigned SAMPLE_BITS      = 16;
  // Quotient bits produced by the divider, one per cycle; the quotient never
  // exceeds the sample magnitude, so it takes a sample's width
  localparam int unsigned QUOT_BITS        = SAMPLE_BITS;
  localparam int unsigned QCNT_BITS        = $clog2(QUOT_BITS);
  // Dividend holds |sample| * count, below 2^(SAMPLE_BITS + FRAME_COUNT_BITS - 1)
  localparam int unsigned DIVIDEND_BITS    = SAMPLE_BITS + FRAME_COUNT_BITS;

  typedef logic [FRAME_COUNT_BITS-1:0] frame_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [DIVIDEND_BITS-1:0] dividend_t;
  typedef logic [QUOT_BITS-1:0] quot_t;

  // Fade applied to the current packet
  typedef enum logic [1:0] {
    FADE_NONE = 2'd0,
    FADE_IN   = 2'd1,
    FADE_OUT  = 2'd2
  } fade_mode_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } seq_state_e;

  // Divider status towards the sequencer
  typedef struct packed {
    logic  done;
    quot_t quot;
  } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/pfs_div.sv
// ----------------------------------------------------------------------------
// pfs_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient must
// fit in QUOT_BITS, i.e. the upper half of the dividend is below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire pfs_pkg::dividend_t dividend_i,
  input  wire pfs_pkg::frame_t    divisor_i,
  output pfs_pkg::div_stat_t      stat_o
);

  logic                                    busy_q, busy_d;
  logic                                    done_q, done_d;
  logic [pfs_pkg::QCNT_BITS-1:0]           cnt_q, cnt_d;
  pfs_pkg::frame_t                         rem_q, rem_d;
  pfs_pkg::frame_t                         dvs_q, dvs_d;
  pfs_pkg::quot_t                          quo_q, quo_d;
  logic [pfs_pkg::FRAME_COUNT_BITS:0]      shifted;
  logic [pfs_pkg::FRAME_COUNT_BITS:0]      diff;
  logic                                    ge;

  // One restoring step
  always_comb begin
    shifted = {rem_q, quo_q[pfs_pkg::QUOT_BITS-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[pfs_pkg::DIVIDEND_BITS-1:pfs_pkg::QUOT_BITS];
      quo_d  = dividend_i[pfs_pkg::QUOT_BITS-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[pfs_pkg::FRAME_COUNT_BITS-1:0] : shifted[pfs_pkg::FRAME_COUNT_BITS-1:0];
      quo_d = {quo_q[pfs_pkg::QUOT_BITS-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pfs_pkg::QCNT_BITS'(pfs_pkg::QUOT_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = quo_q;

endmodule

`default_nettype wire

>>> hdl/pcm_fade_in_out_smoother.sv
// ----------------------------------------------------------------------------
// pcm_fade_in_out_smoother
// Linear fade-in / fade-out of signed 16-bit mono PCM, packet by packet.
// ----------------------------------------------------------------------------
// One sample word is taken at a time and the input stalls until it is done.
// A sample that passes through unchanged goes from the finishing state into the
// output register, and the next one is taken once the sequencer is idle again.
// A faded sample passes through the multiply state, which forms the product and
// loads the divider, 16 steps of the shared bit-serial divider, the divide state
// that takes the quotient, and the finishing state; the next sample is taken once
// the sequencer is idle again.
// The finished word waits in the output register, so the next sample can be
// taken while it stalls; a further finished word waits in the finishing state
// until the register frees. fade_length is written over the configuration
// channel, which is always ready; write it only while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_fade_in_out_smoother (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [15:0]     cfg_fade_length_i,
  // input samples
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic signed [15:0] sample_in_i,
  input  wire logic            has_audio_i,
  input  wire logic [15:0]     packet_frames_i,
  // output samples
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic signed [15:0]   sample_out_o,
  output logic                 packet_end_o
);

  localparam int unsigned FCB = pfs_pkg::FRAME_COUNT_BITS;
  localparam int unsigned SB  = pfs_pkg::SAMPLE_BITS;

  pfs_pkg::seq_state_e state_q, state_d;
  pfs_pkg::frame_t     fade_len_q;
  pfs_pkg::frame_t     pos_q;
  pfs_pkg::frame_t     pkt_len_q;
  pfs_pkg::frame_t     pkt_fade_q;
  logic                pkt_audio_q;
  pfs_pkg::fade_mode_e pkt_mode_q;
  logic                prev_audio_q;
  pfs_pkg::sample_t    held_q;
  logic                out_valid_q;

  // per-sample working registers
  pfs_pkg::sample_t    op_q;
  pfs_pkg::frame_t     num_q;
  logic                sign_q;
  logic                last_q;
  pfs_pkg::sample_t    res_q;
  logic [SB:0]         mag_q;
  pfs_pkg::sample_t    out_sample_q;
  logic                out_end_q;

  logic                in_acc;
  logic                out_free;
  logic                first;
  pfs_pkg::frame_t     len_new, fade_new;
  pfs_pkg::fade_mode_e mode_new;
  pfs_pkg::frame_t     cur_len, cur_fade;
  logic                cur_audio;
  pfs_pkg::fade_mode_e cur_mode;
  logic                do_scale;
  pfs_pkg::frame_t     num_in;
  pfs_pkg::sample_t    op_in;
  logic                last_in;
  logic [SB:0]         mag;
  logic [SB+FCB:0]     prod;
  logic                div_start;
  pfs_pkg::div_stat_t  div_stat;
  logic [SB:0]         quot_ext;
  logic [SB:0]         res_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != pfs_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Packet header decode and per-sample fade decision
  always_comb begin
    first    = (pos_q == '0);
    len_new  = (FCB'(packet_frames_i) == '0) ? FCB'(1) : FCB'(packet_frames_i);
    fade_new = (fade_len_q < len_new) ? fade_len_q : len_new;
    if (fade_new == '0)
      mode_new = pfs_pkg::FADE_NONE;
    else if (has_audio_i && !prev_audio_q)
      mode_new = pfs_pkg::FADE_IN;
    else if (!has_audio_i && prev_audio_q)
      mode_new = pfs_pkg::FADE_OUT;
    else
      mode_new = pfs_pkg::FADE_NONE;
    cur_len   = first ? len_new     : pkt_len_q;
    cur_fade  = first ? fade_new    : pkt_fade_q;
    cur_audio = first ? has_audio_i : pkt_audio_q;
    cur_mode  = first ? mode_new    : pkt_mode_q;
    do_scale  = (cur_mode != pfs_pkg::FADE_NONE) && (pos_q < cur_fade);
    num_in    = (cur_mode == pfs_pkg::FADE_IN) ? pos_q : cur_fade - pos_q;
    op_in     = (cur_mode == pfs_pkg::FADE_IN) ? sample_in_i : held_q;
    last_in   = ({1'b0, pos_q} + (FCB+1)'(1)) >= {1'b0, cur_len};
  end

  // Magnitude times count, fed straight into the divider's registers
  always_comb begin
    mag       = op_q[SB-1] ? ((SB+1)'(0) - {op_q[SB-1], op_q}) : {1'b0, op_q};
    prod      = mag * num_q;
    div_start = (state_q == pfs_pkg::ST_MUL);
    quot_ext  = {1'b0, div_stat.quot};
    res_ext   = sign_q ? ((SB+1)'(0) - quot_ext) : quot_ext;
  end

  pfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod[pfs_pkg::DIVIDEND_BITS-1:0]),
    .divisor_i  (pkt_fade_q),
    .stat_o     (div_stat)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfs_pkg::ST_IDLE: if (in_acc) state_d = do_scale ? pfs_pkg::ST_MUL : pfs_pkg::ST_FIN;
      pfs_pkg::ST_MUL:  state_d = pfs_pkg::ST_DIV;
      pfs_pkg::ST_DIV:  if (div_stat.done) state_d = pfs_pkg::ST_FIN;
      pfs_pkg::ST_FIN:  if (out_free) state_d = pfs_pkg::ST_IDLE;
      default:          state_d = pfs_pkg::ST_IDLE;
    endcase
  end

  // Control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pfs_pkg::ST_IDLE;
      fade_len_q   <= '0;
      pos_q        <= '0;
      pkt_len_q    <= '0;
      pkt_fade_q   <= '0;
      pkt_audio_q  <= 1'b0;
      pkt_mode_q   <= pfs_pkg::FADE_NONE;
      prev_audio_q <= 1'b0;
      held_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fade_len_q <= FCB'(cfg_fade_length_i);
      end
      if (in_acc) begin
        pkt_len_q   <= cur_len;
        pkt_fade_q  <= cur_fade;
        pkt_audio_q <= cur_audio;
        pkt_mode_q  <= cur_mode;
        pos_q       <= last_in ? '0 : pos_q + 1'b1;
      end
      // retire the word into the output register
      if ((state_q == pfs_pkg::ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          if (pkt_fade_q != '0) begin
            held_q <= pkt_audio_q ? res_q : '0;
          end
          prev_audio_q <= pkt_audio_q;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and output data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_in;
      num_q  <= num_in;
      sign_q <= op_in[SB-1];
      last_q <= last_in;
      res_q  <= sample_in_i;
    end
    if (state_q == pfs_pkg::ST_MUL) begin
      mag_q <= mag;
    end
    if ((state_q == pfs_pkg::ST_DIV) && div_stat.done) begin
      res_q <= res_ext[SB-1:0];
    end
    if ((state_q == pfs_pkg::ST_FIN) && out_free) begin
      out_sample_q <= res_q;
      out_end_q    <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign packet_end_o = out_end_q;

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == pfs_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_fade_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pfs_pkg::ST_DIV) && div_stat.done) |-> (quot_ext <= mag_q))
    else $error("faded magnitude exceeds source magnitude");

  a_pos_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) || (pos_q < pkt_len_q))
    else $error("position beyond packet length");

endmodule

`default_nettype wire

>>> dv/tb_pcm_fade_in_out_smoother.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pcm_fade_in_out_smoother
// Self-checking bench for the PCM fade-in / fade-out smoother. Packets of
// audio and silence are pushed in, and a bit-accurate fade model predicts
// each outgoing word. The bench covers directed corners, then random packets
// across several fade lengths and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------

module tb_pcm_fade_in_out_smoother;

  // one predicted output word
  typedef struct {
    pfs_pkg::sample_t sample;
    logic             pkt_end;
  } faded_word_t;

  // --------------------------------------------------------------------------
  // Fade predictor and scoreboard
  // --------------------------------------------------------------------------
  class fade_checker;
    int unsigned         fade_len;
    logic                prev_audio;
    pfs_pkg::sample_t    held;
    int unsigned         pos;
    pfs_pkg::fade_mode_e mode;
    int unsigned         pkt_len;
    int unsigned         pkt_fade;
    logic                pkt_audio;
    faded_word_t         due_words[$];
    int                  errors;

    function new();
      fade_len   = 0;
      prev_audio = 1'b0;
      held       = '0;
      pos        = 0;
      mode       = pfs_pkg::FADE_NONE;
      pkt_len    = 0;
      pkt_fade   = 0;
      pkt_audio  = 1'b0;
      errors     = 0;
    endfunction

    function void set_fade_length(pfs_pkg::frame_t v);
      fade_len = v;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // Work out the word that an accepted sample produces
    function void take_sample(pfs_pkg::sample_t s, logic audio, pfs_pkg::frame_t frames);
      faded_word_t w;
      longint      prod;
      int          r;
      bit          last;
      // packet parameters latch on the first sample only
      if (pos == 0) begin
        pkt_len   = (frames == 0) ? 1 : int'(frames);
        pkt_audio = audio;
        pkt_fade  = (fade_len < pkt_len) ? fade_len : pkt_len;
        if (pkt_fade == 0)
          mode = pfs_pkg::FADE_NONE;
        else if (audio && !prev_audio)
          mode = pfs_pkg::FADE_IN;
        else if (!audio && prev_audio)
          mode = pfs_pkg::FADE_OUT;
        else
          mode = pfs_pkg::FADE_NONE;
      end
      // ramp up from the sample, or down from the held word
      if (mode == pfs_pkg::FADE_IN && pos < pkt_fade) begin
        prod = longint'(s) * longint'(pos);
        r    = int'(prod / longint'(pkt_fade));
      end else if (mode == pfs_pkg::FADE_OUT && pos < pkt_fade) begin
        prod = longint'(held) * longint'(pkt_fade - pos);
        r    = int'(prod / longint'(pkt_fade));
      end else begin
        r = s;
      end
      last = (pos + 1) >= pkt_len;
      if (last) begin
        if (pkt_fade != 0)
          held = pkt_audio ? pfs_pkg::sample_t'(r) : pfs_pkg::sample_t'(0);
        prev_audio = pkt_audio;
        pos        = 0;
        mode       = pfs_pkg::FADE_NONE;
      end else begin
        pos = pos + 1;
      end
      w.sample  = pfs_pkg::sample_t'(r);
      w.pkt_end = last;
      due_words.push_back(w);
    endfunction

    // Compare an accepted output word with the oldest prediction
    function void check_word(pfs_pkg::sample_t got_sample, logic got_end);
      faded_word_t w;
      if (due_words.size() == 0) begin
        $error("unexpected word: sample_out=%0d packet_end=%0b", got_sample, got_end);
        errors++;
        return;
      end
      w = due_words.pop_front();
      if (got_sample !== w.sample) begin
        $error("sample_out: expected %0d, got %0d", w.sample, got_sample);
        errors++;
      end
      if (got_end !== w.pkt_end) begin
        $error("packet_end: expected %0b, got %0b", w.pkt_end, got_end);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  pfs_pkg::frame_t  cfg_fade_length_i;
  logic             in_valid_i;
  logic             in_stall_o;
  pfs_pkg::sample_t sample_in_i;
  logic             has_audio_i;
  pfs_pkg::frame_t  packet_frames_i;
  logic             out_valid_o;
  logic             out_stall_i;
  pfs_pkg::sample_t sample_out_o;
  logic             packet_end_o;

  pcm_fade_in_out_smoother DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_fade_length_i (cfg_fade_length_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_in_i       (sample_in_i),
    .has_audio_i       (has_audio_i),
    .packet_frames_i   (packet_frames_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_out_o      (sample_out_o),
    .packet_end_o      (packet_end_o)
  );

  fade_checker sb;
  int          send_idle_pct;
  int          stall_pct;
  logic        last_audio;

  // clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop if the run hangs
  initial begin
    #2000000;
    $display("tb_pcm_fade_in_out_smoother: FAIL");
    $finish;
  end

  // receiver back-pressure, changed on the falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(sample_out_o, packet_end_o);
  end

  // --------------------------------------------------------------------------
  // Drivers; all entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_word(pfs_pkg::sample_t s, logic audio, pfs_pkg::frame_t frames);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_in_i     <= s;
    has_audio_i     <= audio;
    packet_frames_i <= frames;
    @(posedge clk_i);
    while (in_stall_o)
      @(posedge clk_i);
    sb.take_sample(s, audio, frames);
    @(negedge clk_i);
  endtask

  // hold the input off until every predicted word has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_fade_length(pfs_pkg::frame_t v);
    drain();
    cfg_valid_i       <= 1'b1;
    cfg_fade_length_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o)
      @(posedge clk_i);
    sb.set_fade_length(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pfs_pkg::sample_t pick_sample();
    case ($urandom_range(19))
      0:       return pfs_pkg::sample_t'(16'h7FFF);
      1:       return pfs_pkg::sample_t'(16'h8000);
      2:       return pfs_pkg::sample_t'(0);
      3:       return pfs_pkg::sample_t'(-1);
      default: return pfs_pkg::sample_t'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // one packet of random words; some later words carry junk in the packet fields
  task automatic send_packet(logic audio, pfs_pkg::frame_t frames, ref int sent);
    int              len;
    logic            a;
    pfs_pkg::frame_t f;
    len = (frames == 0) ? 1 : int'(frames);
    for (int i = 0; i < len; i++) begin
      a = audio;
      f = frames;
      if (i > 0 && $urandom_range(99) < 25) begin
        a = 1'($urandom_range(1));
        f = pfs_pkg::frame_t'($urandom_range(16'hFFFF));
      end
      // occasionally let the pipe run dry mid-packet
      if ($urandom_range(99) == 0)
        drain();
      send_word(pick_sample(), a, f);
      sent++;
    end
    last_audio = audio;
  endtask

  task automatic run_packets(int n_words);
    int              sent;
    int              pick;
    pfs_pkg::frame_t frames;
    logic            audio;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 5)
        frames = 0;
      else if (pick < 80)
        frames = pfs_pkg::frame_t'($urandom_range(8, 1));
      else if (pick < 95)
        frames = pfs_pkg::frame_t'($urandom_range(32, 9));
      else
        frames = pfs_pkg::frame_t'($urandom_range(64, 33));
      // favour audio/silence changes so that fades happen often
      audio = ($urandom_range(99) < 65) ? !last_audio : last_audio;
      send_packet(audio, frames, sent);
    end
  endtask

  task automatic run_phase(pfs_pkg::frame_t fade, int send_pct, int st_pct, int n_words,
                           bit with_long);
    int dummy;
    write_fade_length(fade);
    send_idle_pct = send_pct;
    stall_pct     = st_pct;
    dummy         = 0;
    // a long fade-in over a whole packet
    if (with_long) begin
      send_packet(1'b0, 16'd1, dummy);
      send_packet(1'b1, 16'd120, dummy);
    end
    run_packets(n_words);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb                = new();
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_fade_length_i = '0;
    in_valid_i        = 1'b0;
    sample_in_i       = '0;
    has_audio_i       = 1'b0;
    packet_frames_i   = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    last_audio        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fade length still at reset: plain pass-through, held word untouched
    send_word(pfs_pkg::sample_t'(16'h7FFF), 1'b1, 16'd2);
    send_word(pfs_pkg::sample_t'(16'h8000), 1'b1, 16'd2);
    send_word(pfs_pkg::sample_t'(1234), 1'b0, 16'd1);

    // fade-in over 4 of 6 words, junk packet fields mid-packet, drain mid-way
    write_fade_length(16'd4);
    send_word(pfs_pkg::sample_t'(16'h7FFF), 1'b1, 16'd6);
    send_word(pfs_pkg::sample_t'(16'h8000), 1'b0, 16'hFFFF);
    send_word(pfs_pkg::sample_t'(16'h7FFF), 1'b1, 16'd6);
    drain();
    send_word(pfs_pkg::sample_t'(16'h8000), 1'b0, 16'h8000);
    send_word(pfs_pkg::sample_t'(1000), 1'b1, 16'd6);
    send_word(pfs_pkg::sample_t'(16'h8000), 1'b1, 16'd6);

    // fade-out from the most negative held word
    send_word(pfs_pkg::sample_t'(5), 1'b0, 16'd5);
    send_word(pfs_pkg::sample_t'(-5), 1'b0, 16'd5);
    send_word(pfs_pkg::sample_t'(16'h7FFF), 1'b0, 16'd5);
    send_word(pfs_pkg::sample_t'(0), 1'b0, 16'd5);
    send_word(pfs_pkg::sample_t'(77), 1'b0, 16'd5);

    // zero packet length is a one-word packet, here faded in at index 0
    send_word(pfs_pkg::sample_t'(16'h7FFF), 1'b1, 16'd0);

    // audio after audio keeps the last word; then a fade shorter than 4
    send_word(pfs_pkg::sample_t'(-3), 1'b1, 16'd2);
    send_word(pfs_pkg::sample_t'(16'h7FFF), 1'b1, 16'd2);
    send_word(pfs_pkg::sample_t'(9), 1'b0, 16'd3);
    send_word(pfs_pkg::sample_t'(9), 1'b0, 16'd3);
    send_word(pfs_pkg::sample_t'(9), 1'b0, 16'd3);
    last_audio = 1'b0;

    // random packets over a spread of fade lengths and idle patterns
    run_phase(16'hFFFF, 0, 0, 55, 1'b1);
    run_phase(16'd1, 74, 0, 55, 1'b0);
    run_phase(16'd0, 0, 74, 55, 1'b0);
    run_phase(pfs_pkg::frame_t'($urandom_range(16, 2)), 10, 10, 55, 1'b0);
    run_phase(16'hFFFF, 74, 0, 55, 1'b0);
    run_phase(pfs_pkg::frame_t'($urandom_range(40, 2)), 0, 74, 55, 1'b0);
    run_phase(16'd8, 0, 0, 55, 1'b0);
    run_phase(pfs_pkg::frame_t'($urandom_range(16'hFFFF)), 10, 10, 55, 1'b0);

    // let the tail drain, then watch for stray words
    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb_pcm_fade_in_out_smoother: PASS");
    else
      $display("tb_pcm_fade_in_out_smoother: FAIL");
    $finish;
  end

endmodule

>>> pcm_fade_in_out_smoother.f
hdl/pfs_pkg.sv
hdl/pfs_div.sv
hdl/pcm_fade_in_out_smoother.sv
dv/tb_pcm_fade_in_out_smoother.sv
